// ----- rtl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the Jacobi symbol unit
// Field widths, symbol codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int VALUE_W   = 63;
    localparam int MODULUS_W = 63;
    localparam int SYMBOL_W  = 2;

    typedef logic signed [SYMBOL_W-1:0] t_symbol;

    localparam t_symbol SYM_POS  = 2'sb01;
    localparam t_symbol SYM_ZERO = 2'sb00;
    localparam t_symbol SYM_NEG  = 2'sb11;

    // residues that flip the sign
    localparam logic [2:0] MOD8_THREE = 3'd3;
    localparam logic [2:0] MOD8_FIVE  = 3'd5;
    localparam logic [1:0] MOD4_THREE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;   // take a new operand pair
        logic strip;  // drop one factor of two from the value
        logic swap;   // swap operands and start the remainder
        logic div;    // one shift-subtract step
        logic emit;   // load the result register
    } t_cmd;

    typedef struct packed {
        logic top_zero;
        logic top_odd;
        logic div_last;
    } t_stat;

endpackage

// ----- rtl/jsu_if.sv -----
// ----------------------------------------------------------------------------
// jsu_if: valid/ready channels of the Jacobi symbol unit
// Input channel carries an operand pair, output channel carries the symbol.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic                          valid;
    logic                          ready;
    logic [jsu_pkg::VALUE_W-1:0]   value;
    logic [jsu_pkg::MODULUS_W-1:0] modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface jsu_out_if;
    logic             valid;
    logic             ready;
    jsu_pkg::t_symbol symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

// ----- rtl/jsu_dp.sv -----
// ----------------------------------------------------------------------------
// jsu_dp: Jacobi symbol datapath
// Operand registers, sign flag, bit-serial remainder and result register.
// ----------------------------------------------------------------------------
module jsu_dp #(
    parameter int WORD_BITS = 64
) (
    input  logic                          i_clk,
    input  logic [jsu_pkg::VALUE_W-1:0]   i_value,
    input  logic [jsu_pkg::MODULUS_W-1:0] i_modulus,
    input  jsu_pkg::t_cmd                 i_cmd,
    output jsu_pkg::t_stat                o_stat,
    output jsu_pkg::t_symbol              o_symbol
);
    import jsu_pkg::*;

    localparam int OW = WORD_BITS - 1;
    localparam int CW = $clog2(OW);
    localparam logic [CW-1:0] CNT_INIT = CW'(OW - 1);

    logic [OW-1:0] r_top, n_top;
    logic [OW-1:0] r_bot, n_bot;
    logic [OW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_neg, n_neg;
    t_symbol       r_symbol, n_symbol;

    logic [OW:0]   rem_sh;
    logic [OW:0]   rem_diff;
    logic [OW-1:0] rem_next;
    logic          flip8;
    logic          flip4;

    always_comb begin
        rem_sh   = {r_rem, r_top[OW-1]};
        rem_diff = rem_sh - {1'b0, r_bot};
        // borrow set means the shifted remainder stays below the divisor
        rem_next = rem_diff[OW] ? rem_sh[OW-1:0] : rem_diff[OW-1:0];
        flip8    = (r_bot[2:0] == MOD8_THREE) || (r_bot[2:0] == MOD8_FIVE);
        flip4    = (r_bot[1:0] == MOD4_THREE) && (r_top[1:0] == MOD4_THREE);
    end

    always_comb begin
        n_top    = r_top;
        n_bot    = r_bot;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_symbol = r_symbol;
        if (i_cmd.load) begin
            n_top = i_value[OW-1:0];
            n_bot = i_modulus[OW-1:0];
            n_neg = 1'b0;
        end else if (i_cmd.strip) begin
            n_top = r_top >> 1;
            n_neg = r_neg ^ flip8;
        end else if (i_cmd.swap) begin
            n_top = r_bot;
            n_bot = r_top;
            n_neg = r_neg ^ flip4;
            n_rem = '0;
            n_cnt = CNT_INIT;
        end else if (i_cmd.div) begin
            n_rem = rem_next;
            n_cnt = r_cnt - 1'b1;
            n_top = (r_cnt == '0) ? rem_next : (r_top << 1);
        end
        if (i_cmd.emit) begin
            if (r_bot == OW'(1)) begin
                n_symbol = r_neg ? SYM_NEG : SYM_POS;
            end else begin
                n_symbol = SYM_ZERO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_bot    <= n_bot;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_symbol <= n_symbol;
    end

    assign o_stat.top_zero = (r_top == '0);
    assign o_stat.top_odd  = r_top[0];
    assign o_stat.div_last = (r_cnt == '0);
    assign o_symbol        = r_symbol;

endmodule

// ----- rtl/jsu_ctrl.sv -----
// ----------------------------------------------------------------------------
// jsu_ctrl: Jacobi symbol controller
// Sequences strip, swap and remainder steps and owns the output valid flag.
// ----------------------------------------------------------------------------
module jsu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  jsu_pkg::t_stat i_stat,
    output jsu_pkg::t_cmd  o_cmd
);
    import jsu_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = (r_out_valid && !i_out_ready) ? 1'b1 : 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (i_stat.top_zero) begin
                    n_state = ST_FINISH;
                end else if (!i_stat.top_odd) begin
                    o_cmd.strip = 1'b1;
                end else begin
                    o_cmd.swap = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_REDUCE;
                end
            end
            ST_FINISH: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/jacobi_symbol_unit.sv -----
// Each remainder is a restoring shift-subtract over the OW = WORD_BITS - 1
// bits of the value, one bit per step. One item in flight: no new item is
// accepted until the symbol has been written to the output register.
// Synchronous active-low reset clears the state machine and output valid.
// ----------------------------------------------------------------------------
// jacobi_symbol_unit: binary Jacobi symbol (a/p)
// Controller plus datapath. Returns +1, -1 or 0 for one operand pair per item.
// ----------------------------------------------------------------------------
module jacobi_symbol_unit #(
    parameter int WORD_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);
    import jsu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Controller: IDLE takes an item, REDUCE strips a two per cycle, swaps the
    // operands once the value is odd or ends once it is zero, DIV runs the
    // remainder bit by bit, FINISH drops the symbol into the output register once it is free.
    jsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: operands are kept in WORD_BITS-1 bits, upper input bits dropped.
    jsu_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_value   (i_in.value),
        .i_modulus (i_in.modulus),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_symbol  (o_out.symbol)
    );

endmodule

// ----- rtl/jsu_checker.sv -----
// ----------------------------------------------------------------------------
// jsu_checker: port-level assertions for the Jacobi symbol unit
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input jsu_pkg::t_symbol i_symbol
);
    import jsu_pkg::*;

    // no code outside -1, 0, +1
    a_symbol_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_symbol == SYM_POS || i_symbol == SYM_ZERO ||
                         i_symbol == SYM_NEG))
        else $error("symbol code out of range");

    // busy after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken twice in a row");

    // a result never appears the cycle after an item is accepted
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result came too early");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output valid dropped");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_symbol))
        else $error("stalled symbol changed");

endmodule

bind jacobi_symbol_unit jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_symbol    (o_out.symbol)
);
